// ===== design/ffsa_pkg.sv =====
// Shared types and constants for the first-fit segment allocator.
// No dependencies; every other design file but ffsa_ram refers to this package by scoped names.
`default_nettype none

package ffsa_pkg;

   // Default sizing, handed to the top level as parameter defaults
   localparam int MEM_UNITS_DEF  = 65536;
   localparam int MAX_OWNERS_DEF = 16;

   // Compaction reports at most this many owners
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = 5;

   // Operation codes
   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_COMPACT = 2'd2,
      OP_CHECK   = 2'd3
   } op_type;

   // Result status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_SHORT     = 3'd1;
   localparam logic [2:0] STAT_NO_HOLE   = 3'd2;
   localparam logic [2:0] STAT_NOT_HELD  = 3'd3;
   localparam logic [2:0] STAT_ALREADY   = 3'd4;
   localparam logic [2:0] STAT_ZERO_SIZE = 3'd5;

   typedef struct packed {
      op_type      op;
      logic [3:0]  owner_id;
      logic [16:0] req_size;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] base_address;
      logic [3:0]  report_owner;
      logic        compact_needed;
      logic [16:0] free_left;
      logic        last;
   } rsp_type;

   // One entry of the segment table
   typedef struct packed {
      logic [15:0] start;
      logic [16:0] length;
      logic        is_free;
      logic [3:0]  holder;
   } seg_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EX,
      S_DECIDE,
      S_STR_RD,
      S_STR_EX,
      S_FLUSH,
      S_RESP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic init;
      logic load;
      logic scan_ex;
      logic decide;
      logic str_ex;
      logic flush;
      logic respond;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_end;
      logic modify;
      logic ex_wait;
      logic slot_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== design/ffsa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ffsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write on enable, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/ffsa_ctrl.sv =====
// Sequencer of the segment allocator: scan pass, rewrite pass, result beat.
// Depends on ffsa_pkg.
`default_nettype none

module ffsa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ffsa_pkg::sts_type sts,
   output ffsa_pkg::cmd_type     cmd
);

   ffsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffsa_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffsa_pkg::S_INIT:    state_in = ffsa_pkg::S_IDLE;
         ffsa_pkg::S_IDLE:    if (req_valid) state_in = ffsa_pkg::S_SCAN_RD;
         ffsa_pkg::S_SCAN_RD: state_in = sts.scan_end ? ffsa_pkg::S_DECIDE
                                                      : ffsa_pkg::S_SCAN_EX;
         ffsa_pkg::S_SCAN_EX: state_in = ffsa_pkg::S_SCAN_RD;
         ffsa_pkg::S_DECIDE:  state_in = sts.modify ? ffsa_pkg::S_STR_RD
                                                    : ffsa_pkg::S_RESP;
         ffsa_pkg::S_STR_RD:  state_in = sts.scan_end ? ffsa_pkg::S_FLUSH
                                                      : ffsa_pkg::S_STR_EX;
         ffsa_pkg::S_STR_EX:  if (!sts.ex_wait) state_in = ffsa_pkg::S_STR_RD;
         ffsa_pkg::S_FLUSH:   state_in = ffsa_pkg::S_RESP;
         ffsa_pkg::S_RESP:    if (sts.slot_free) state_in = ffsa_pkg::S_IDLE;
         default:             state_in = ffsa_pkg::S_INIT;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ffsa_pkg::S_INIT:    cmd.init = 1'b1;
         ffsa_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ffsa_pkg::S_SCAN_RD: ;
         ffsa_pkg::S_SCAN_EX: cmd.scan_ex = 1'b1;
         ffsa_pkg::S_DECIDE:  cmd.decide = 1'b1;
         ffsa_pkg::S_STR_RD:  ;
         ffsa_pkg::S_STR_EX:  cmd.str_ex = !sts.ex_wait;
         ffsa_pkg::S_FLUSH:   cmd.flush = 1'b1;
         ffsa_pkg::S_RESP:    cmd.respond = sts.slot_free;
         default:             ;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/ffsa_dp.sv =====
// Datapath of the segment allocator: two table banks, scan registers, stream
// rewrite, result register. Depends on ffsa_pkg and ffsa_ram.
`default_nettype none

module ffsa_dp #(
   parameter int MEM_UNITS  = ffsa_pkg::MEM_UNITS_DEF,
   parameter int MAX_OWNERS = ffsa_pkg::MAX_OWNERS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ffsa_pkg::req_type req_data,
   input  wire ffsa_pkg::cmd_type cmd,
   output ffsa_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ffsa_pkg::rsp_type      rsp_data
);

   localparam int DEPTH = 2 * MAX_OWNERS + 1;
   localparam int IW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SEG_W = $bits(ffsa_pkg::seg_type);
   localparam logic [16:0] MEM_LEN = 17'(MEM_UNITS);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [ffsa_pkg::RES_CNT_W-1:0] RES_MAX =
      ffsa_pkg::RES_CNT_W'(ffsa_pkg::MAX_RESULTS);

   // Table state
   logic bank_ff, bank_in;
   logic [CW-1:0] count_ff, count_in;
   logic [16:0] free_total_ff, free_total_in;

   // Request and walk registers
   ffsa_pkg::op_type op_ff, op_in;
   logic [3:0]    owner_ff, owner_in;
   logic [16:0]   size_ff, size_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] w_ff, w_in;

   // Scan results
   logic          held_v_ff, held_v_in;
   logic [CW-1:0] held_idx_ff, held_idx_in;
   logic [16:0]   held_len_ff, held_len_in;
   logic          fit_v_ff, fit_v_in;
   logic [CW-1:0] fit_idx_ff, fit_idx_in;
   logic [16:0]   fit_len_ff, fit_len_in;
   logic [15:0]   fit_start_ff, fit_start_in;
   logic [16:0]   largest_ff, largest_in;
   logic [2:0]    st_ff, st_in;

   // Stream rewrite
   logic              acc_v_ff, acc_v_in;
   ffsa_pkg::seg_type acc_ff, acc_in;
   logic [16:0]       next_ff, next_in;
   logic [ffsa_pkg::RES_CNT_W-1:0] k_ff, k_in;
   logic              pend_v_ff, pend_v_in;
   logic [15:0]       pend_start_ff, pend_start_in;
   logic [3:0]        pend_owner_ff, pend_owner_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   ffsa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Memory ports and helpers
   logic [SEG_W-1:0]  rd_data0, rd_data1;
   logic              wr_en, wr_bank;
   logic [IW-1:0]     wr_addr;
   ffsa_pkg::seg_type wr_data;
   ffsa_pkg::seg_type x, y_seg, alloc_seg, rem_seg, tail_seg, init_seg;
   logic [2:0]        st_calc;
   logic              own_ok, split, slot_free, need_emit, emit;
   ffsa_pkg::rsp_type emit_data;

   ffsa_ram #(.WIDTH(SEG_W), .DEPTH(DEPTH)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && !wr_bank),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_data0)
   );

   ffsa_ram #(.WIDTH(SEG_W), .DEPTH(DEPTH)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && wr_bank),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_data1)
   );

   // Current entry and its rewritten forms
   always_comb begin
      x = bank_ff ? ffsa_pkg::seg_type'(rd_data1) : ffsa_pkg::seg_type'(rd_data0);

      y_seg = x;
      if (idx_ff == held_idx_ff) begin
         y_seg.is_free = 1'b1;
         y_seg.holder  = 4'd0;
      end

      alloc_seg.start   = x.start;
      alloc_seg.length  = size_ff;
      alloc_seg.is_free = 1'b0;
      alloc_seg.holder  = owner_ff;

      rem_seg.start   = x.start + size_ff[15:0];
      rem_seg.length  = x.length - size_ff;
      rem_seg.is_free = 1'b1;
      rem_seg.holder  = 4'd0;

      tail_seg.start   = next_ff[15:0];
      tail_seg.length  = MEM_LEN - next_ff;
      tail_seg.is_free = 1'b1;
      tail_seg.holder  = 4'd0;

      init_seg.start   = 16'd0;
      init_seg.length  = MEM_LEN;
      init_seg.is_free = 1'b1;
      init_seg.holder  = 4'd0;
   end

   // Decide the outcome from the scan
   assign own_ok = int'(owner_ff) < MAX_OWNERS;
   assign split  = fit_len_ff > size_ff;

   always_comb begin
      st_calc = ffsa_pkg::STAT_OK;
      unique case (op_ff)
         ffsa_pkg::OP_ALLOC: begin
            if (size_ff == 17'd0)            st_calc = ffsa_pkg::STAT_ZERO_SIZE;
            else if (!own_ok)                st_calc = ffsa_pkg::STAT_NOT_HELD;
            else if (held_v_ff)              st_calc = ffsa_pkg::STAT_ALREADY;
            else if (size_ff > free_total_ff) st_calc = ffsa_pkg::STAT_SHORT;
            else if (!fit_v_ff)              st_calc = ffsa_pkg::STAT_NO_HOLE;
            else if (split && count_ff >= DEPTH_C) st_calc = ffsa_pkg::STAT_NO_HOLE;
         end
         ffsa_pkg::OP_FREE: begin
            if (!own_ok || !held_v_ff) st_calc = ffsa_pkg::STAT_NOT_HELD;
         end
         default: ;
      endcase
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign need_emit = (op_ff == ffsa_pkg::OP_COMPACT) && !x.is_free &&
                      (k_ff < RES_MAX) && pend_v_ff;

   always_comb begin
      sts.scan_end  = (idx_ff == count_ff);
      sts.modify    = (op_ff == ffsa_pkg::OP_COMPACT) ||
                      (((op_ff == ffsa_pkg::OP_ALLOC) || (op_ff == ffsa_pkg::OP_FREE)) &&
                       (st_calc == ffsa_pkg::STAT_OK));
      sts.ex_wait   = need_emit && !slot_free;
      sts.slot_free = slot_free;
   end

   // Next-value logic for all commands
   always_comb begin
      bank_in       = bank_ff;
      count_in      = count_ff;
      free_total_in = free_total_ff;
      op_in         = op_ff;
      owner_in      = owner_ff;
      size_in       = size_ff;
      idx_in        = idx_ff;
      w_in          = w_ff;
      held_v_in     = held_v_ff;
      held_idx_in   = held_idx_ff;
      held_len_in   = held_len_ff;
      fit_v_in      = fit_v_ff;
      fit_idx_in    = fit_idx_ff;
      fit_len_in    = fit_len_ff;
      fit_start_in  = fit_start_ff;
      largest_in    = largest_ff;
      st_in         = st_ff;
      acc_v_in      = acc_v_ff;
      acc_in        = acc_ff;
      next_in       = next_ff;
      k_in          = k_ff;
      pend_v_in     = pend_v_ff;
      pend_start_in = pend_start_ff;
      pend_owner_in = pend_owner_ff;
      wr_en         = 1'b0;
      wr_bank       = !bank_ff;
      wr_addr       = w_ff[IW-1:0];
      wr_data       = acc_ff;
      emit          = 1'b0;
      emit_data     = '0;

      // Seed the one free segment after reset
      if (cmd.init) begin
         wr_en   = 1'b1;
         wr_bank = 1'b0;
         wr_addr = '0;
         wr_data = init_seg;
      end

      // Take the request beat
      if (cmd.load) begin
         op_in      = req_data.op;
         owner_in   = req_data.owner_id;
         size_in    = req_data.req_size;
         idx_in     = '0;
         held_v_in  = 1'b0;
         fit_v_in   = 1'b0;
         largest_in = 17'd0;
      end

      // Scan one entry: first fit, largest hole, owner's segment
      if (cmd.scan_ex) begin
         if (x.is_free) begin
            if (!fit_v_ff && x.length >= size_ff) begin
               fit_v_in     = 1'b1;
               fit_idx_in   = idx_ff;
               fit_len_in   = x.length;
               fit_start_in = x.start;
            end
            if (x.length > largest_ff) largest_in = x.length;
         end else if (!held_v_ff && x.holder == owner_ff) begin
            held_v_in   = 1'b1;
            held_idx_in = idx_ff;
            held_len_in = x.length;
         end
         idx_in = idx_ff + 1'b1;
      end

      // Latch the outcome and arm the rewrite
      if (cmd.decide) begin
         st_in     = st_calc;
         idx_in    = '0;
         w_in      = '0;
         acc_v_in  = 1'b0;
         next_in   = 17'd0;
         k_in      = '0;
         pend_v_in = 1'b0;
      end

      // Rewrite one entry into the other bank
      if (cmd.str_ex) begin
         case (op_ff)
            ffsa_pkg::OP_ALLOC: begin
               wr_en = 1'b1;
               w_in  = w_ff + 1'b1;
               if (idx_ff == fit_idx_ff) begin
                  wr_data = alloc_seg;
                  if (split) begin
                     acc_v_in = 1'b1;
                     acc_in   = rem_seg;
                  end
               end else if (acc_v_ff) begin
                  wr_data = acc_ff;
                  acc_in  = x;
               end else begin
                  wr_data = x;
               end
            end
            ffsa_pkg::OP_FREE: begin
               if (acc_v_ff && acc_ff.is_free && y_seg.is_free) begin
                  acc_in.length = acc_ff.length + y_seg.length;
               end else begin
                  if (acc_v_ff) begin
                     wr_en = 1'b1;
                     w_in  = w_ff + 1'b1;
                  end
                  acc_in   = y_seg;
                  acc_v_in = 1'b1;
               end
            end
            ffsa_pkg::OP_COMPACT: begin
               if (!x.is_free) begin
                  wr_en          = 1'b1;
                  wr_data.start  = next_ff[15:0];
                  wr_data.length = x.length;
                  wr_data.is_free = 1'b0;
                  wr_data.holder = x.holder;
                  w_in           = w_ff + 1'b1;
                  next_in        = next_ff + x.length;
                  if (k_ff < RES_MAX) begin
                     if (pend_v_ff) begin
                        emit                   = 1'b1;
                        emit_data.base_address = pend_start_ff;
                        emit_data.report_owner = pend_owner_ff;
                        emit_data.free_left    = free_total_ff;
                     end
                     pend_v_in     = 1'b1;
                     pend_start_in = next_ff[15:0];
                     pend_owner_in = x.holder;
                     k_in          = k_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
         idx_in = idx_ff + 1'b1;
      end

      // Drain the held entry or the free tail, switch banks
      if (cmd.flush) begin
         bank_in  = !bank_ff;
         count_in = w_ff;
         if (op_ff == ffsa_pkg::OP_COMPACT) begin
            if (next_ff < MEM_LEN) begin
               wr_en    = 1'b1;
               wr_data  = tail_seg;
               count_in = w_ff + 1'b1;
            end
         end else if (acc_v_ff) begin
            wr_en    = 1'b1;
            wr_data  = acc_ff;
            count_in = w_ff + 1'b1;
         end
         if (op_ff == ffsa_pkg::OP_ALLOC) free_total_in = free_total_ff - size_ff;
         if (op_ff == ffsa_pkg::OP_FREE)  free_total_in = free_total_ff + held_len_ff;
      end

      // Final result beat
      if (cmd.respond) begin
         emit                = 1'b1;
         emit_data.last      = 1'b1;
         emit_data.free_left = free_total_ff;
         case (op_ff)
            ffsa_pkg::OP_ALLOC: begin
               emit_data.status       = st_ff;
               emit_data.base_address = (st_ff == ffsa_pkg::STAT_OK) ? fit_start_ff : 16'd0;
               emit_data.report_owner = owner_ff;
            end
            ffsa_pkg::OP_FREE: begin
               emit_data.status       = st_ff;
               emit_data.report_owner = owner_ff;
            end
            ffsa_pkg::OP_COMPACT: begin
               if (pend_v_ff) begin
                  emit_data.base_address = pend_start_ff;
                  emit_data.report_owner = pend_owner_ff;
               end
            end
            default: begin
               emit_data.compact_needed = (free_total_ff >= size_ff) &&
                                          (largest_ff < size_ff);
            end
         endcase
      end

      // Output register: load on a new beat, drop once taken
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff       <= 1'b0;
         count_ff      <= CW'(1);
         free_total_ff <= MEM_LEN;
         rsp_valid_ff  <= 1'b0;
         acc_v_ff      <= 1'b0;
         pend_v_ff     <= 1'b0;
         held_v_ff     <= 1'b0;
         fit_v_ff      <= 1'b0;
         idx_ff        <= '0;
         w_ff          <= '0;
         k_ff          <= '0;
      end else begin
         bank_ff       <= bank_in;
         count_ff      <= count_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         acc_v_ff      <= acc_v_in;
         pend_v_ff     <= pend_v_in;
         held_v_ff     <= held_v_in;
         fit_v_ff      <= fit_v_in;
         idx_ff        <= idx_in;
         w_ff          <= w_in;
         k_ff          <= k_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      owner_ff      <= owner_in;
      size_ff       <= size_in;
      held_idx_ff   <= held_idx_in;
      held_len_ff   <= held_len_in;
      fit_idx_ff    <= fit_idx_in;
      fit_len_ff    <= fit_len_in;
      fit_start_ff  <= fit_start_in;
      largest_ff    <= largest_in;
      st_ff         <= st_in;
      acc_ff        <= acc_in;
      next_ff       <= next_in;
      pend_start_ff <= pend_start_in;
      pend_owner_ff <= pend_owner_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/first_fit_segment_allocator_top.sv =====
// First-fit segment allocator over a table of up to 2*MAX_OWNERS+1 segments
// covering MEM_UNITS units. One request beat is taken at a time. Each request
// makes one scan of the N current segments (N up to 33 by default); then a
// successful allocate or free, and every compact, rewrite the table into a
// second bank. The result channel can stall a result beat and so hold up the
// request. The table walk goes through the single read port of each bank.
// After reset the block seeds the table before it takes a request. Compact
// returns one result beat per held segment (at most 16; one if none is held);
// every other request returns exactly one. Depends on ffsa_pkg, ffsa_ctrl,
// ffsa_dp.
`default_nettype none

module first_fit_segment_allocator_top #(
   parameter int MEM_UNITS  = ffsa_pkg::MEM_UNITS_DEF,
   parameter int MAX_OWNERS = ffsa_pkg::MAX_OWNERS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ffsa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ffsa_pkg::rsp_type      rsp_data
);

   ffsa_pkg::cmd_type cmd;
   ffsa_pkg::sts_type sts;

   ffsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffsa_dp #(.MEM_UNITS(MEM_UNITS), .MAX_OWNERS(MAX_OWNERS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/ffsa_checker.sv =====
// Port-level checks for the segment allocator, bound to the top level.
// Depends on ffsa_pkg and first_fit_segment_allocator_top.
`default_nettype none

module ffsa_checker #(
   parameter int MEM_UNITS = ffsa_pkg::MEM_UNITS_DEF
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire ffsa_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire ffsa_pkg::rsp_type rsp_data
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // One request at a time: busy right after a beat is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // Free space never exceeds memory
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.free_left <= 17'(MEM_UNITS))
      else $error("free total beyond memory size");

   // An error ends the request's results
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ffsa_pkg::STAT_OK |-> rsp_data.last)
      else $error("error result without last");

endmodule

bind first_fit_segment_allocator_top ffsa_checker #(.MEM_UNITS(MEM_UNITS)) u_ffsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== verif/first_fit_segment_allocator_top_tb.sv =====
// Self-checking bench for the first-fit segment allocator: a table model in the
// bench predicts every result beat, which is compared field by field in order.
// Depends on ffsa_pkg and first_fit_segment_allocator_top.
`default_nettype none

module first_fit_segment_allocator_top_tb;

   localparam int MEM    = 65536;
   localparam int OWNERS = 16;
   localparam int DEPTH  = 2 * OWNERS + 1;
   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   ffsa_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   ffsa_pkg::rsp_type rsp_data;

   first_fit_segment_allocator_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bench copy of the segment table
   logic [15:0] tbl_start [DEPTH];
   logic [16:0] tbl_len   [DEPTH];
   logic        tbl_free  [DEPTH];
   logic [3:0]  tbl_owner [DEPTH];
   int          tbl_count;
   logic [16:0] tbl_free_total;

   ffsa_pkg::rsp_type expected_beats [$];
   int      mismatches = 0;
   int      items_sent = 0;
   int      beats_seen = 0;
   int      compacts_sent = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      idle_cycles = 0;

   function automatic int find_owner(logic [3:0] who);
      for (int i = 0; i < tbl_count; i++)
         if (!tbl_free[i] && tbl_owner[i] == who) return i;
      return -1;
   endfunction

   function automatic void drop_entry(int idx);
      for (int i = idx; i + 1 < tbl_count; i++) begin
         tbl_start[i] = tbl_start[i + 1];
         tbl_len[i]   = tbl_len[i + 1];
         tbl_free[i]  = tbl_free[i + 1];
         tbl_owner[i] = tbl_owner[i + 1];
      end
      tbl_count--;
   endfunction

   function automatic ffsa_pkg::rsp_type make_beat(logic [2:0] st, logic [15:0] base,
                                                   logic [3:0] who, logic need, logic lst);
      ffsa_pkg::rsp_type r;
      r.status = st; r.base_address = base; r.report_owner = who;
      r.compact_needed = need; r.free_left = tbl_free_total; r.last = lst;
      return r;
   endfunction

   function automatic void reset_table();
      for (int i = 0; i < DEPTH; i++) begin
         tbl_start[i] = '0; tbl_len[i] = '0; tbl_free[i] = 1'b0; tbl_owner[i] = '0;
      end
      tbl_len[0] = 17'(MEM); tbl_free[0] = 1'b1;
      tbl_count = 1; tbl_free_total = 17'(MEM);
   endfunction

   function automatic logic [2:0] predict_alloc(logic [3:0] who, logic [16:0] sz,
                                                output logic [15:0] base);
      int i;
      base = '0;
      if (sz == 0) return ffsa_pkg::STAT_ZERO_SIZE;
      if (find_owner(who) >= 0) return ffsa_pkg::STAT_ALREADY;
      if (sz > tbl_free_total) return ffsa_pkg::STAT_SHORT;
      for (i = 0; i < tbl_count; i++)
         if (tbl_free[i] && tbl_len[i] >= sz) break;
      if (i >= tbl_count) return ffsa_pkg::STAT_NO_HOLE;
      if (tbl_len[i] > sz) begin
         if (tbl_count >= DEPTH) return ffsa_pkg::STAT_NO_HOLE;
         for (int j = tbl_count; j > i + 1; j--) begin
            tbl_start[j] = tbl_start[j - 1]; tbl_len[j] = tbl_len[j - 1];
            tbl_free[j] = tbl_free[j - 1]; tbl_owner[j] = tbl_owner[j - 1];
         end
         tbl_start[i + 1] = tbl_start[i] + 16'(sz);
         tbl_len[i + 1] = tbl_len[i] - sz;
         tbl_free[i + 1] = 1'b1; tbl_owner[i + 1] = '0;
         tbl_len[i] = sz;
         tbl_count++;
      end
      tbl_free[i] = 1'b0; tbl_owner[i] = who;
      tbl_free_total -= sz;
      base = tbl_start[i];
      return ffsa_pkg::STAT_OK;
   endfunction

   function automatic logic [2:0] predict_free(logic [3:0] who);
      int i;
      i = find_owner(who);
      if (i < 0) return ffsa_pkg::STAT_NOT_HELD;
      tbl_free_total += tbl_len[i];
      tbl_free[i] = 1'b1; tbl_owner[i] = '0;
      if (i + 1 < tbl_count && tbl_free[i + 1]) begin
         tbl_len[i] += tbl_len[i + 1]; drop_entry(i + 1);
      end
      if (i > 0 && tbl_free[i - 1]) begin
         tbl_len[i - 1] += tbl_len[i]; drop_entry(i);
      end
      return ffsa_pkg::STAT_OK;
   endfunction

   // Work out every result beat of one request and queue them
   function automatic void predict_request(ffsa_pkg::req_type rq);
      logic [15:0] base;
      logic [2:0]  st;
      logic        need;
      logic [16:0] next, largest;
      int j, k, first;
      case (rq.op)
         ffsa_pkg::OP_ALLOC: begin
            st = predict_alloc(rq.owner_id, rq.req_size, base);
            expected_beats.push_back(make_beat(st, base, rq.owner_id, 1'b0, 1'b1));
         end
         ffsa_pkg::OP_FREE: begin
            st = predict_free(rq.owner_id);
            expected_beats.push_back(make_beat(st, '0, rq.owner_id, 1'b0, 1'b1));
         end
         ffsa_pkg::OP_COMPACT: begin
            j = 0; k = 0; next = '0; first = expected_beats.size();
            for (int i = 0; i < tbl_count; i++) begin
               if (!tbl_free[i]) begin
                  tbl_start[j] = 16'(next); tbl_len[j] = tbl_len[i];
                  tbl_free[j] = 1'b0; tbl_owner[j] = tbl_owner[i];
                  next += tbl_len[j];
                  if (k < ffsa_pkg::MAX_RESULTS) begin
                     expected_beats.push_back(make_beat(ffsa_pkg::STAT_OK, tbl_start[j],
                                                        tbl_owner[j], 1'b0, 1'b0));
                     k++;
                  end
                  j++;
               end
            end
            if (next < MEM) begin
               tbl_start[j] = 16'(next); tbl_len[j] = 17'(MEM) - next;
               tbl_free[j] = 1'b1; tbl_owner[j] = '0; j++;
            end
            tbl_count = j;
            if (k == 0) begin
               expected_beats.push_back(make_beat(ffsa_pkg::STAT_OK, '0, '0, 1'b0, 1'b1));
            end else begin
               expected_beats[first + k - 1].last = 1'b1;
            end
         end
         default: begin
            largest = '0;
            for (int i = 0; i < tbl_count; i++)
               if (tbl_free[i] && tbl_len[i] > largest) largest = tbl_len[i];
            need = (tbl_free_total >= rq.req_size) && (largest < rq.req_size);
            expected_beats.push_back(make_beat(ffsa_pkg::STAT_OK, '0, '0, need, 1'b1));
         end
      endcase
   endfunction

   // Send one request beat, holding it until accepted
   task automatic send_request(ffsa_pkg::op_type op, logic [3:0] who, logic [16:0] sz);
      ffsa_pkg::req_type rq;
      rq.op = op; rq.owner_id = who; rq.req_size = sz;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_data  <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(rq);
      items_sent++;
      if (op == ffsa_pkg::OP_COMPACT) compacts_sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Check each accepted result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", rsp_data);
         end else begin
            ffsa_pkg::rsp_type exp_beat;
            exp_beat = expected_beats.pop_front();
            if (rsp_data !== exp_beat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, actual %p", exp_beat, rsp_data);
            end
         end
      end
   end

   // Stall the result channel at random
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // Watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic test_extremes();
      send_request(ffsa_pkg::OP_CHECK, 4'd0, 17'd0);
      send_request(ffsa_pkg::OP_ALLOC, 4'd0, 17'd0);
      send_request(ffsa_pkg::OP_ALLOC, 4'd1, 17'h1FFFF);
      send_request(ffsa_pkg::OP_ALLOC, 4'd15, 17'd65536);
      send_request(ffsa_pkg::OP_ALLOC, 4'd15, 17'd1);
      send_request(ffsa_pkg::OP_FREE, 4'd15, '0);
      send_request(ffsa_pkg::OP_FREE, 4'd15, '0);
      send_request(ffsa_pkg::OP_COMPACT, 4'd0, '0);
   endtask

   task automatic test_fragmentation();
      for (int i = 0; i < 8; i++) send_request(ffsa_pkg::OP_ALLOC, 4'(i), 17'd8192);
      send_request(ffsa_pkg::OP_ALLOC, 4'd9, 17'd1);
      send_request(ffsa_pkg::OP_FREE, 4'd1, '0);
      send_request(ffsa_pkg::OP_FREE, 4'd3, '0);
      send_request(ffsa_pkg::OP_FREE, 4'd2, '0);
      send_request(ffsa_pkg::OP_FREE, 4'd5, '0);
      send_request(ffsa_pkg::OP_CHECK, 4'd0, 17'd30000);
      send_request(ffsa_pkg::OP_ALLOC, 4'd9, 17'd30000);
      send_request(ffsa_pkg::OP_COMPACT, 4'd0, '0);
      send_request(ffsa_pkg::OP_CHECK, 4'd0, 17'd30000);
      send_request(ffsa_pkg::OP_ALLOC, 4'd9, 17'd30000);
   endtask

   // Mostly alloc/free traffic with small sizes, some big or zero ones, compacts and checks
   task automatic test_random(int count);
      ffsa_pkg::op_type op;
      logic [16:0] sz;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: op = ffsa_pkg::OP_ALLOC;
            4, 5, 6:    op = ffsa_pkg::OP_FREE;
            7:          op = ffsa_pkg::OP_COMPACT;
            default:    op = ffsa_pkg::OP_CHECK;
         endcase
         case ($urandom_range(9))
            0:       sz = 17'($urandom_range(17'h1FFFF));
            1:       sz = 17'($urandom_range(65536, 8192));
            2:       sz = '0;
            default: sz = 17'($urandom_range(6000, 1));
         endcase
         send_request(op, 4'($urandom_range(15)), sz);
      end
   endtask

   initial begin
      reset_table();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 18; recv_idle_pct = 82;
      test_extremes();
      test_fragmentation();
      test_random(60);
      wait_drained();
      send_idle_pct = 82; recv_idle_pct = 18;
      test_random(60);
      wait_drained();
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(60);
      wait_drained();
      $display("sent %0d requests (%0d compactions), checked %0d result beats",
               items_sent, compacts_sent, beats_seen);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d beats missing", mismatches, expected_beats.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

`default_nettype wire
